[rtl/rsa_pkg.sv]
// Shared types and constants of the region sector allocator.
`timescale 1ns / 1ps
package rsa_pkg;

  // Fixed geometry of the slot table and of a chunk header.
  localparam int CHUNK_SLOTS        = 1024;
  localparam int SLOT_W             = 10;
  localparam int CHUNK_HEADER_BYTES = 8;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Width that holds a region size in sectors at the largest sector count.
  localparam int OPEN_SECT_W = 17;

  typedef enum logic [1:0] {
    CMD_OPEN   = 2'd0,
    CMD_CLAIM  = 2'd1,
    CMD_STORE  = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_SIZE    = 3'd1,
    ST_BAD_RANGE   = 3'd2,
    ST_OVERLAP     = 3'd3,
    ST_BAD_PAYLOAD = 3'd4,
    ST_TOO_LARGE   = 3'd5,
    ST_CAPACITY    = 3'd6
  } status_t;

  // A decoded command with every check that needs no stored state already done.
  typedef struct packed {
    cmd_t                   cmd;
    logic [SLOT_W-1:0]      slot;
    logic [31:0]            stamp;
    logic                   open_bad;
    logic [OPEN_SECT_W-1:0] open_sectors;
    logic                   claim_zero;
    logic                   claim_shape_ok;
    logic [23:0]            claim_start;
    logic [7:0]             claim_count;
    logic                   payload_ok;
    logic [7:0]             store_needed;
    logic                   store_too_large;
  } rsa_op_t;

endpackage

[rtl/rsa_if.sv]
// Channel interfaces for the command input and the result output.
`timescale 1ns / 1ps
interface rsa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [23:0] region_bytes;
  logic [4:0]  chunk_x;
  logic [4:0]  chunk_z;
  logic [31:0] offset_word;
  logic [31:0] stamp;
  logic [31:0] payload_word;
  logic [31:0] decoded_length;
  logic [19:0] compressed_length;

  modport source (
    output valid, command, region_bytes, chunk_x, chunk_z, offset_word, stamp,
           payload_word, decoded_length, compressed_length,
    input  ready
  );
  modport sink (
    input  valid, command, region_bytes, chunk_x, chunk_z, offset_word, stamp,
           payload_word, decoded_length, compressed_length,
    output ready
  );
endinterface

interface rsa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        present;
  logic [10:0] sector_start;
  logic [7:0]  sector_count;
  logic [31:0] stamp_out;
  logic [11:0] region_sectors_out;
  logic [23:0] grown_bytes;

  modport source (
    output valid, status, present, sector_start, sector_count, stamp_out,
           region_sectors_out, grown_bytes,
    input  ready
  );
  modport sink (
    input  valid, status, present, sector_start, sector_count, stamp_out,
           region_sectors_out, grown_bytes,
    output ready
  );
endinterface

[rtl/rsa_front.sv]
// Front part: accepts command transactions and decodes the stateless checks.
`timescale 1ns / 1ps
module rsa_front #(
  parameter int SECTOR_BYTES = 4096,
  parameter int MAX_SECTORS  = 2048
) (
  rsa_in_if.sink            in_chan,
  input  logic              q_full,
  input  logic              init_busy,
  output logic              q_push,
  output rsa_pkg::rsa_op_t  q_entry
);
  import rsa_pkg::*;

  localparam int          SB_LOG     = $clog2(SECTOR_BYTES);
  localparam logic [47:0] SAVE_LIMIT = 48'(SECTOR_BYTES) * 48'(MAX_SECTORS);

  logic [24:0] open_round;
  logic [32:0] pay_cap;
  logic [32:0] pay_need;
  logic [20:0] store_sum;
  logic [13:0] store_need;
  logic        open_empty;

  // A transaction is taken whenever the queue has room and the reset pass is over.
  assign in_chan.ready = !q_full && !init_busy;
  assign q_push        = in_chan.valid && in_chan.ready;

  // Decode the command and work out the checks that depend on the inputs only.
  always_comb begin
    open_empty = (in_chan.region_bytes == '0);
    open_round = 25'(in_chan.region_bytes) + 25'(SECTOR_BYTES - 1);
    pay_cap    = 33'(in_chan.offset_word[7:0]) << SB_LOG;
    pay_need   = 33'(in_chan.payload_word[30:0]) + 33'(CHUNK_HEADER_BYTES);
    store_sum  = 21'(in_chan.compressed_length) + 21'(CHUNK_HEADER_BYTES);
    store_need = 14'(store_sum >> SB_LOG) + 14'd1;

    q_entry.cmd   = cmd_t'(in_chan.command);
    q_entry.slot  = {in_chan.chunk_z, in_chan.chunk_x};
    q_entry.stamp = in_chan.stamp;

    q_entry.open_bad = !open_empty &&
                       ((48'(in_chan.region_bytes) < 48'(2 * SECTOR_BYTES)) ||
                        (48'(in_chan.region_bytes) > SAVE_LIMIT));
    q_entry.open_sectors = open_empty ? OPEN_SECT_W'(2)
                                      : OPEN_SECT_W'(open_round >> SB_LOG);

    q_entry.claim_zero     = (in_chan.offset_word == '0);
    q_entry.claim_start    = in_chan.offset_word[31:8];
    q_entry.claim_count    = in_chan.offset_word[7:0];
    q_entry.claim_shape_ok = (in_chan.offset_word[31:8] >= 24'd2) &&
                             (in_chan.offset_word[7:0] != '0);
    q_entry.payload_ok     = (in_chan.payload_word[30:0] != '0) &&
                             (pay_need <= pay_cap) &&
                             (48'(in_chan.decoded_length) <= SAVE_LIMIT);

    q_entry.store_needed    = store_need[7:0];
    q_entry.store_too_large = (store_need >= 14'd256);
  end

endmodule

[rtl/rsa_queue.sv]
// Short queue of decoded commands between the front and back parts.
`timescale 1ns / 1ps
module rsa_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_push,
  input  rsa_pkg::rsa_op_t  q_in,
  output logic              q_full,
  output logic              q_valid,
  input  logic              q_pop,
  output rsa_pkg::rsa_op_t  q_out
);
  import rsa_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  rsa_op_t       entry_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   count_r;
  logic          do_push;
  logic          do_pop;

  assign q_full  = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_out   = entry_r[rd_ptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && q_valid;

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= q_in;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

endmodule

[rtl/rsa_engine.sv]
// Back part: owns the slot table and sector bitmap and carries out each command.
`timescale 1ns / 1ps
module rsa_engine #(
  parameter int SECTOR_BYTES = 4096,
  parameter int MAX_SECTORS  = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  rsa_pkg::rsa_op_t  q_data,
  output logic              q_pop,
  output logic              init_busy,
  rsa_out_if.source         out_chan
);
  import rsa_pkg::*;

  localparam int SB_LOG = $clog2(SECTOR_BYTES);
  localparam int SW     = $clog2(MAX_SECTORS);
  localparam int RW     = $clog2(MAX_SECTORS + 1);
  localparam int KW     = $clog2(MAX_SECTORS + 256);
  localparam int SWEEP  = (MAX_SECTORS > CHUNK_SLOTS) ? MAX_SECTORS : CHUNK_SLOTS;
  localparam int CW     = $clog2(SWEEP);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_OLD_RD, S_OLD_CAP, S_SCAN,
    S_FREE, S_MARK, S_WRITE, S_RES_RD, S_RES_CAP
  } state_t;

  typedef enum logic [1:0] {CONT_IDLE, CONT_RESULT, CONT_STORE} cont_t;

  typedef struct packed {
    logic [SW-1:0] start;
    logic [7:0]    count;
    logic [31:0]   stamp;
  } slot_t;

  // Memories.
  slot_t slot_mem [CHUNK_SLOTS];
  logic  map_mem  [MAX_SECTORS];
  slot_t slot_rd_r;
  logic  map_rd_r;

  logic              slot_we, slot_re;
  logic [SLOT_W-1:0] slot_wa;
  slot_t             slot_wd;
  logic              map_we, map_re, map_wd;
  logic [SW-1:0]     map_wa, map_ra;

  // Control and context registers.
  state_t        state_r;
  cont_t         cont_r;
  logic [CW-1:0] clr_cnt_r;
  logic [RW-1:0] clr_target_r;
  rsa_op_t       op_r;
  status_t       status_r;
  logic [SW-1:0] os_r;
  logic [7:0]    on_r;
  logic [KW-1:0] start_r;
  logic [7:0]    cnt_r;
  logic [KW-1:0] k_r, k_end_r;
  logic [KW-1:0] iss_r, end_r, pidx_r;
  logic          pend_r;
  logic [7:0]    run_r;
  logic [KW-1:0] rstart_r;
  logic [RW-1:0] region_r;
  logic [23:0]   growth_r;

  logic          out_valid_r;
  status_t       out_status_r;
  logic          out_present_r;
  logic [10:0]   out_start_r;
  logic [7:0]    out_count_r;
  logic [31:0]   out_stamp_r;
  logic [11:0]   out_region_r;
  logic [23:0]   out_grown_r;

  // Derived conditions.
  logic          clr_last, clr_slot, clr_map, clr_free;
  logic          scan_issue, p_in_old, p_free, k_more, k_in_map;
  logic [KW-1:0] old_end;
  logic [7:0]    run_inc;
  logic [24:0]   claim_s_w, region_w;
  logic          range_bad, cap_bad;

  always_comb begin
    clr_last   = (clr_cnt_r == CW'(SWEEP - 1));
    clr_slot   = ({1'b0, clr_cnt_r} < (CW+1)'(CHUNK_SLOTS));
    clr_map    = ({1'b0, clr_cnt_r} < (CW+1)'(MAX_SECTORS));
    clr_free   = ({1'b0, clr_cnt_r} >= (CW+1)'(2)) &&
                 ({1'b0, clr_cnt_r} < (CW+1)'(clr_target_r));
    scan_issue = (iss_r < end_r);
    old_end    = KW'(os_r) + KW'(on_r);
    p_in_old   = (pidx_r >= KW'(os_r)) && (pidx_r < old_end);
    p_free     = map_rd_r || p_in_old;
    run_inc    = run_r + 8'd1;
    k_more     = (k_r < k_end_r);
    k_in_map   = (k_r < KW'(MAX_SECTORS));
    claim_s_w  = {1'b0, op_r.claim_start};
    region_w   = 25'(region_r);
    range_bad  = !op_r.claim_shape_ok || (claim_s_w >= region_w) ||
                 (25'(op_r.claim_count) > (region_w - claim_s_w));
    cap_bad    = (32'(op_r.store_needed) > (32'(MAX_SECTORS) - 32'(region_r)));
  end

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign init_busy = (state_r == S_CLEAR) && (cont_r == CONT_IDLE);

  // Memory port control per state.
  always_comb begin
    slot_we = 1'b0;
    slot_re = 1'b0;
    slot_wa = op_r.slot;
    slot_wd = '{start: start_r[SW-1:0], count: cnt_r, stamp: op_r.stamp};
    map_we  = 1'b0;
    map_re  = 1'b0;
    map_wa  = k_r[SW-1:0];
    map_wd  = 1'b0;
    map_ra  = iss_r[SW-1:0];
    unique case (state_r)
      S_CLEAR: begin
        slot_we = clr_slot;
        slot_wa = clr_cnt_r[SLOT_W-1:0];
        slot_wd = '0;
        map_we  = clr_map;
        map_wa  = clr_cnt_r[SW-1:0];
        map_wd  = clr_free;
      end
      S_OLD_RD, S_RES_RD: begin
        slot_re = 1'b1;
      end
      S_SCAN: begin
        map_re = scan_issue;
      end
      S_FREE: begin
        map_we = k_more && k_in_map;
        map_wd = 1'b1;
      end
      S_MARK: begin
        map_we = k_more;
      end
      S_WRITE: begin
        slot_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Slot table: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (slot_re) begin
      slot_rd_r <= slot_mem[op_r.slot];
    end
  end

  // Sector bitmap, a set bit marks a free sector.
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (map_re) begin
      map_rd_r <= map_mem[map_ra];
    end
  end

  // Command sequencer with the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cont_r       <= CONT_IDLE;
      clr_cnt_r    <= '0;
      clr_target_r <= '0;
      region_r     <= '0;
      growth_r     <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        // Sweep both stores; the bitmap is left free from sector 2 to the region end.
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + CW'(1);
          if (clr_last) begin
            clr_cnt_r <= '0;
            unique case (cont_r)
              CONT_IDLE:   state_r <= S_IDLE;
              CONT_RESULT: state_r <= S_RES_RD;
              CONT_STORE:  state_r <= S_OLD_RD;
              default:     state_r <= S_IDLE;
            endcase
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            op_r    <= q_data;
            state_r <= S_DISPATCH;
          end
        end
        // Checks of the decoded command and against the region size, before anything is changed.
        S_DISPATCH: begin
          status_r <= ST_OK;
          unique case (op_r.cmd)
            CMD_LOOKUP: state_r <= S_RES_RD;
            CMD_OPEN: begin
              if (op_r.open_bad) begin
                status_r <= ST_BAD_SIZE;
                state_r  <= S_RES_RD;
              end else begin
                clr_target_r <= RW'(op_r.open_sectors);
                region_r     <= RW'(op_r.open_sectors);
                growth_r     <= '0;
                cont_r       <= CONT_RESULT;
                state_r      <= S_CLEAR;
              end
            end
            CMD_CLAIM: begin
              if (!op_r.claim_zero && range_bad) begin
                status_r <= ST_BAD_RANGE;
                state_r  <= S_RES_RD;
              end else begin
                state_r <= S_OLD_RD;
              end
            end
            CMD_STORE: begin
              if (op_r.store_too_large) begin
                status_r <= ST_TOO_LARGE;
                state_r  <= S_RES_RD;
              end else if (region_r < RW'(2)) begin
                clr_target_r <= RW'(2);
                region_r     <= RW'(2);
                growth_r     <= '0;
                cont_r       <= CONT_STORE;
                state_r      <= S_CLEAR;
              end else begin
                state_r <= S_OLD_RD;
              end
            end
            default: state_r <= S_RES_RD;
          endcase
        end
        S_OLD_RD: begin
          state_r <= S_OLD_CAP;
        end
        // The slot's old run is known here; set up the scan or the plain update.
        S_OLD_CAP: begin
          os_r    <= slot_rd_r.start;
          on_r    <= slot_rd_r.count;
          k_r     <= KW'(slot_rd_r.start);
          k_end_r <= KW'(slot_rd_r.start) + KW'(slot_rd_r.count);
          pend_r  <= 1'b0;
          run_r   <= '0;
          if (op_r.cmd == CMD_CLAIM) begin
            if (op_r.claim_zero) begin
              start_r <= '0;
              cnt_r   <= '0;
              state_r <= S_FREE;
            end else begin
              iss_r   <= KW'(op_r.claim_start);
              end_r   <= KW'(op_r.claim_start) + KW'(op_r.claim_count);
              state_r <= S_SCAN;
            end
          end else if (op_r.cmd == CMD_STORE) begin
            if ((slot_rd_r.start != '0) && (slot_rd_r.count == op_r.store_needed)) begin
              start_r <= KW'(slot_rd_r.start);
              cnt_r   <= slot_rd_r.count;
              state_r <= S_WRITE;
            end else begin
              iss_r   <= KW'(2);
              end_r   <= KW'(region_r);
              state_r <= S_SCAN;
            end
          end else begin
            state_r <= S_RES_RD;
          end
        end
        // One bitmap bit a cycle: overlap test for claim, first fit for store.
        S_SCAN: begin
          pend_r <= scan_issue;
          pidx_r <= iss_r;
          if (scan_issue) begin
            iss_r <= iss_r + KW'(1);
          end
          if (pend_r) begin
            if (op_r.cmd == CMD_CLAIM) begin
              if (!p_free) begin
                status_r <= ST_OVERLAP;
                state_r  <= S_RES_RD;
              end
            end else if (!p_free) begin
              run_r <= '0;
            end else begin
              run_r <= run_inc;
              if (run_r == '0) begin
                rstart_r <= pidx_r;
              end
              if (run_inc >= op_r.store_needed) begin
                start_r <= (run_r == '0) ? pidx_r : rstart_r;
                cnt_r   <= op_r.store_needed;
                state_r <= S_FREE;
              end
            end
          end else if (!scan_issue) begin
            if (op_r.cmd == CMD_CLAIM) begin
              if (!op_r.payload_ok) begin
                status_r <= ST_BAD_PAYLOAD;
                state_r  <= S_RES_RD;
              end else begin
                start_r <= KW'(op_r.claim_start);
                cnt_r   <= op_r.claim_count;
                state_r <= S_FREE;
              end
            end else if (cap_bad) begin
              status_r <= ST_CAPACITY;
              state_r  <= S_RES_RD;
            end else begin
              // No free run fits: append at the region end.
              start_r  <= KW'(region_r);
              cnt_r    <= op_r.store_needed;
              region_r <= RW'(32'(region_r) + 32'(op_r.store_needed));
              growth_r <= growth_r + 24'(32'(op_r.store_needed) << SB_LOG);
              state_r  <= S_FREE;
            end
          end
        end
        // Release the old run.
        S_FREE: begin
          if (k_more) begin
            k_r <= k_r + KW'(1);
          end else begin
            k_r     <= start_r;
            k_end_r <= start_r + KW'(cnt_r);
            state_r <= S_MARK;
          end
        end
        // Take the new run.
        S_MARK: begin
          if (k_more) begin
            k_r <= k_r + KW'(1);
          end else begin
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          state_r <= S_RES_RD;
        end
        S_RES_RD: begin
          state_r <= S_RES_CAP;
        end
        // Report the slot as it stands once the output register is free.
        S_RES_CAP: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= status_r;
            out_present_r <= (slot_rd_r.start != '0) || (slot_rd_r.count != '0);
            out_start_r   <= 11'(slot_rd_r.start);
            out_count_r   <= slot_rd_r.count;
            out_stamp_r   <= slot_rd_r.stamp;
            out_region_r  <= 12'(region_r);
            out_grown_r   <= growth_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.status             = out_status_r;
  assign out_chan.present            = out_present_r;
  assign out_chan.sector_start       = out_start_r;
  assign out_chan.sector_count       = out_count_r;
  assign out_chan.stamp_out          = out_stamp_r;
  assign out_chan.region_sectors_out = out_region_r;
  assign out_chan.grown_bytes        = out_grown_r;

endmodule

[rtl/region_sector_allocator_unit.sv]
// Region sector allocator: slot table and sector bitmap of one region file.
// Commands arrive as transactions on in_chan and each yields one result transaction on
// out_chan describing the addressed slot after the command. A two-entry queue sits
// between command decode and the sequencer, and results leave through an output
// register, so new commands are taken while a result waits. The sequencer visits the
// sector bitmap one sector per cycle, which sets the timing. Lookup and a command
// rejected at decode read the slot and report; claim scans its range for overlap
// (stopping early at a taken sector), releases the old run and takes the new one;
// store scans the region for a first fit and otherwise appends at the region end,
// or keeps the slot's run when its size matches; open, and a store on a region never
// opened, add a clearing pass over both stores. After reset the same clearing pass
// runs and in_chan.ready stays low until it ends. SECTOR_BYTES must be a power of
// two.
`timescale 1ns / 1ps
module region_sector_allocator_unit #(
  parameter int SECTOR_BYTES = 4096,
  parameter int MAX_SECTORS  = 2048
) (
  input  logic      clk,
  input  logic      rst_n,
  rsa_in_if.sink    in_chan,
  rsa_out_if.source out_chan
);
  import rsa_pkg::*;

  rsa_op_t q_in;
  rsa_op_t q_out;
  logic    q_push, q_full, q_valid, q_pop, init_busy;

  rsa_front #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .MAX_SECTORS  (MAX_SECTORS)
  ) u_front (
    .in_chan   (in_chan),
    .q_full    (q_full),
    .init_busy (init_busy),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  rsa_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_in    (q_in),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_out   (q_out)
  );

  rsa_engine #(
    .SECTOR_BYTES (SECTOR_BYTES),
    .MAX_SECTORS  (MAX_SECTORS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_chan  (out_chan)
  );

endmodule

[rtl/rsa_checker.sv]
// Port-level checks on the result channel of the region sector allocator.
`timescale 1ns / 1ps
module rsa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic        out_present,
  input logic [10:0] out_sector_start,
  input logic [7:0]  out_sector_count,
  input logic [31:0] out_stamp_out
);

  // A result offered and not taken stays offered.
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction withdrawn before it was taken");

  // A stalled result keeps its contents.
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_present) &&
      $stable(out_sector_start) && $stable(out_sector_count) && $stable(out_stamp_out))
    else $error("result transaction changed while stalled");

  // No result is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // An occupied slot always has a nonzero run length, an empty one none.
  a_present_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_present == (out_sector_count != 8'd0)))
    else $error("present flag disagrees with sector count");

endmodule

bind region_sector_allocator_unit rsa_checker u_rsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_status       (out_chan.status),
  .out_present      (out_chan.present),
  .out_sector_start (out_chan.sector_start),
  .out_sector_count (out_chan.sector_count),
  .out_stamp_out    (out_chan.stamp_out)
);
